FILE: hdl/efb_pkg.sv
package efb_pkg;

	localparam int MaxWrites = 9;
	localparam int IdxW      = 4;

	// result kinds
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_HANDLER = 2'd1;
	localparam logic [1:0] KIND_NOFRAME = 2'd2;

	// frame format words
	localparam logic [15:0] FMT7_WORD = 16'h7008;
	localparam logic [15:0] FMT2_TAG  = 16'h2000;
	localparam logic [15:0] FMT3_TAG  = 16'h3000;
	localparam logic [15:0] FMT1_TAG  = 16'h1000;

	// status word bits
	localparam int SR_T1 = 15;
	localparam int SR_T0 = 14;
	localparam int SR_S  = 13;
	localparam int SR_M  = 12;
	localparam int SSW_CT = 13;

	// stack bytes taken by each frame
	localparam logic [5:0] BYTES_FMT7 = 6'd60;
	localparam logic [5:0] BYTES_FMT2 = 6'd12;
	localparam logic [5:0] BYTES_FMT0 = 6'd8;

	typedef enum logic [2:0] {
		FR_NONE,
		FR_ACCESS,
		FR_ADDR_ERR,
		FR_TRAP,
		FR_FMT0_IPC,
		FR_FMT0_NPC,
		FR_FP,
		FR_IRQ
	} frame_class_t;

	typedef struct packed {
		logic [7:0]  vector;
		logic [15:0] status_word;
		logic [31:0] next_pc;
		logic [31:0] instr_pc;
		logic [31:0] fault_address;
		logic [31:0] effective_address;
		logic [15:0] fault_status;
		logic        trace_pending;
		logic [31:0] interrupt_sp;
		logic [31:0] master_sp;
	} efb_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [15:0] write_data;
		logic [15:0] new_status;
		logic [31:0] new_interrupt_sp;
		logic [31:0] new_master_sp;
		logic        last;
	} efb_out_t;

endpackage

FILE: hdl/efb_beat_gen.sv
module efb_beat_gen (
	input  efb_pkg::efb_in_t       item,
	input  logic [efb_pkg::IdxW-1:0] idx,
	input  logic [31:0]            vbase,
	output efb_pkg::efb_out_t      beat
);
	import efb_pkg::*;

	frame_class_t fclass;
	logic         on_master;
	logic [31:0]  sp0;
	logic [15:0]  ssw_ct;
	logic [31:0]  ea_sel;
	logic [31:0]  a_sel;
	logic [31:0]  pc_sel;
	logic [15:0]  fmt_word;
	logic [15:0]  vec_word;
	logic [15:0]  wdata [MaxWrites];
	logic [5:0]   woff [MaxWrites];
	logic [IdxW-1:0] nwr;
	logic [5:0]   tot;
	logic [IdxW-1:0] widx;
	logic [31:0]  wbase;
	logic [15:0]  st;
	logic [31:0]  isp_new;
	logic [31:0]  msp_new;
	logic         irq_switch;

	assign on_master  = item.status_word[SR_M];
	assign sp0        = on_master ? item.master_sp : item.interrupt_sp;
	assign vec_word   = {6'd0, item.vector, 2'b00};
	assign ssw_ct     = item.fault_status | {2'b00, item.trace_pending, 13'd0};
	assign ea_sel     = (ssw_ct[15:12] != 4'd0) ? item.effective_address : 32'd0;

	always_comb begin
		case (item.vector) inside
			8'd2:                         fclass = FR_ACCESS;
			8'd3:                         fclass = FR_ADDR_ERR;
			8'd5, 8'd6, 8'd7, 8'd9:       fclass = FR_TRAP;
			8'd4, 8'd8, 8'd10, 8'd11, 8'd14: fclass = FR_FMT0_IPC;
			[8'd32:8'd47]:                fclass = FR_FMT0_NPC;
			[8'd48:8'd55]:                fclass = FR_FP;
			8'd15, [8'd24:8'd31]:         fclass = FR_IRQ;
			default:                      fclass = FR_NONE;
		endcase
	end

	assign irq_switch = (fclass == FR_IRQ) && on_master;

	always_comb begin
		a_sel    = item.instr_pc;
		pc_sel   = item.next_pc;
		fmt_word = FMT2_TAG | vec_word;
		case (fclass)
			FR_ADDR_ERR: begin
				a_sel  = {item.fault_address[31:1], 1'b0};
				pc_sel = item.instr_pc;
			end
			FR_TRAP: begin
				a_sel  = item.instr_pc;
				pc_sel = item.next_pc;
			end
			FR_FP: begin
				a_sel    = item.effective_address;
				fmt_word = FMT3_TAG | vec_word;
			end
			FR_FMT0_IPC: pc_sel = item.instr_pc;
			default: pc_sel = item.next_pc;
		endcase
	end

	// push list in order, with the byte distance below the starting stack pointer
	always_comb begin
		wdata = '{default: 16'd0};
		woff  = '{default: 6'd0};
		nwr   = '0;
		tot   = 6'd0;
		case (fclass)
			FR_ACCESS: begin
				wdata = '{item.fault_address[15:0], item.fault_address[31:16], ssw_ct,
					ea_sel[15:0], ea_sel[31:16], FMT7_WORD,
					item.instr_pc[15:0], item.instr_pc[31:16], item.status_word};
				woff  = '{6'd38, 6'd40, 6'd48, 6'd50, 6'd52, 6'd54, 6'd56, 6'd58, 6'd60};
				nwr   = IdxW'(9);
				tot   = BYTES_FMT7;
			end
			FR_ADDR_ERR, FR_TRAP, FR_FP: begin
				wdata = '{a_sel[15:0], a_sel[31:16], fmt_word, pc_sel[15:0], pc_sel[31:16],
					item.status_word, 16'd0, 16'd0, 16'd0};
				woff  = '{6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd0, 6'd0, 6'd0};
				nwr   = IdxW'(6);
				tot   = BYTES_FMT2;
			end
			FR_FMT0_IPC, FR_FMT0_NPC, FR_IRQ: begin
				// second half is the throwaway frame on the interrupt stack
				wdata = '{vec_word, pc_sel[15:0], pc_sel[31:16], item.status_word,
					FMT1_TAG | vec_word, item.next_pc[15:0], item.next_pc[31:16],
					item.status_word, 16'd0};
				woff  = '{6'd2, 6'd4, 6'd6, 6'd8, 6'd2, 6'd4, 6'd6, 6'd8, 6'd0};
				nwr   = irq_switch ? IdxW'(8) : IdxW'(4);
				tot   = BYTES_FMT0;
			end
			default: begin
				nwr = '0;
				tot = 6'd0;
			end
		endcase
	end

	assign widx  = (idx < IdxW'(MaxWrites)) ? idx : '0;
	assign wbase = (irq_switch && idx >= IdxW'(4)) ? item.interrupt_sp : sp0;

	always_comb begin
		st = (item.status_word | 16'h2000) & 16'h3FFF;
		if (fclass == FR_IRQ) begin
			st[10:8] = item.vector[2:0];
			if (on_master)
				st[SR_M] = 1'b0;
		end
	end

	assign msp_new = on_master ? (item.master_sp - {26'd0, tot}) : item.master_sp;
	assign isp_new = (!on_master || irq_switch) ? (item.interrupt_sp - {26'd0, tot})
		: item.interrupt_sp;

	always_comb begin
		if (idx == nwr) begin
			beat.write_data       = 16'd0;
			beat.new_status       = st;
			beat.new_interrupt_sp = isp_new;
			beat.new_master_sp    = msp_new;
			beat.last             = 1'b1;
			if (fclass == FR_NONE) begin
				beat.kind    = KIND_NOFRAME;
				beat.address = 32'd0;
			end else begin
				beat.kind    = KIND_HANDLER;
				beat.address = vbase + {22'd0, item.vector, 2'b00};
			end
		end else begin
			beat.kind             = KIND_WRITE;
			beat.address          = wbase - {26'd0, woff[widx]};
			beat.write_data       = wdata[widx];
			beat.new_status       = 16'd0;
			beat.new_interrupt_sp = 32'd0;
			beat.new_master_sp    = 32'd0;
			beat.last             = 1'b0;
		end
	end

endmodule

FILE: hdl/exception_frame_builder.sv
// Request path: a request is registered in item_s1, and each result beat
// is built from it and registered in res_q.
// Beats: a request gives one result beat per stack write plus a final beat,
// 1 to 10 beats, held back by res_stall; the next request is taken as the final beat loads.
// Reset: arst_n clears all valids, the write index and vector_base to zero.
module exception_frame_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  efb_pkg::efb_in_t    req,
	output logic                res_valid,
	input  logic                res_stall,
	output efb_pkg::efb_out_t   res,
	input  logic                wr_en,
	input  logic [31:0]         wr_data
);
	import efb_pkg::*;

	efb_in_t         item_s1;
	logic            valid_s1;
	logic [IdxW-1:0] idx_q;
	logic [31:0]     vbase_q;
	efb_out_t        res_q;
	logic            res_valid_q;
	efb_out_t        beat;
	logic            load;
	logic            done;
	logic            take;

	efb_beat_gen u_beat (
		.item  (item_s1),
		.idx   (idx_q),
		.vbase (vbase_q),
		.beat  (beat)
	);

	assign load      = valid_s1 && (!res_valid_q || !res_stall);
	assign done      = load && beat.last;
	assign req_stall = valid_s1 && !done;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			vbase_q     <= 32'd0;
		end else begin
			if (wr_en)
				vbase_q <= wr_data;
			if (take)
				valid_s1 <= 1'b1;
			else if (done)
				valid_s1 <= 1'b0;
			if (load)
				idx_q <= beat.last ? '0 : idx_q + IdxW'(1);
			if (load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= req;
		if (load)
			res_q <= beat;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
